[rtl/dpfb_pkg.sv]
package dpfb_pkg;

    // image size defaults
    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;

    // filter and label constants
    localparam logic [15:0] EDGE_JUMP_MM     = 16'd200;
    localparam logic [7:0]  BACKGROUND_LABEL = 8'd255;
    localparam int          INSTANCE_SHIFT   = 16;

    // fixed point of the projection
    localparam int          FRAC_SHIFT  = 28;
    localparam int          PROD_W      = 56;
    localparam logic [28:0] OUT_MAX     = 29'd8388607;
    localparam logic [28:0] OUT_NEG_MAG = 29'd8388608;

    // register reset values
    localparam logic [23:0] INV_FX_RST   = 24'd31336;
    localparam logic [23:0] INV_FY_RST   = 24'd31115;
    localparam logic [15:0] CENTER_X_RST = 16'd5122;
    localparam logic [15:0] CENTER_Y_RST = 16'd3962;
    localparam logic [15:0] DEPTH_MIN_RST = 16'd100;
    localparam logic [15:0] DEPTH_MAX_RST = 16'd8000;
    localparam logic [31:0] EXCL_LIST_RST = 32'd0;
    localparam logic [2:0]  EXCL_CNT_RST  = 3'd1;

    typedef enum logic [2:0] {
        REG_INV_FOCAL_X  = 3'd0,
        REG_INV_FOCAL_Y  = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_DEPTH_MIN    = 3'd4,
        REG_DEPTH_MAX    = 3'd5,
        REG_EXCL_LIST    = 3'd6,
        REG_EXCL_COUNT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] near_mm;
        logic [15:0] far_mm;
        logic [31:0] excluded_list;
        logic [2:0]  excluded_count;
    } t_cfg;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] depth_mm;
        logic [15:0] depth_up;
        logic [15:0] depth_down;
        logic [15:0] depth_left;
        logic [15:0] depth_right;
        logic [7:0]  mask_label;
        logic [15:0] instance_in;
    } t_pix;

    // load strobes of the four pipeline stages
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } t_pipe_ctl;

endpackage

[rtl/dpfb_ifs.sv]
interface dpfb_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth_mm;
    logic [15:0] depth_up;
    logic [15:0] depth_down;
    logic [15:0] depth_left;
    logic [15:0] depth_right;
    logic [7:0]  mask_label;
    logic [15:0] instance_in;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;

    modport source (
        output valid, col, row, depth_mm, depth_up, depth_down, depth_left, depth_right,
               mask_label, instance_in, blue_in, green_in, red_in,
        input  ready
    );
    modport sink (
        input  valid, col, row, depth_mm, depth_up, depth_down, depth_left, depth_right,
               mask_label, instance_in, blue_in, green_in, red_in,
        output ready
    );
endinterface

interface dpfb_pnt_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [15:0]        point_z;
    logic [31:0]        point_label;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;

    modport source (
        output valid, point_x, point_y, point_z, point_label, blue_out, green_out, red_out,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, point_label, blue_out, green_out, red_out,
        output ready
    );
endinterface

interface dpfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/dpfb_cfg_regs.sv]
module dpfb_cfg_regs
    import dpfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpfb_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_INV_FOCAL_X: n_cfg.inv_focal_x    = i_cfg.data[23:0];
                REG_INV_FOCAL_Y: n_cfg.inv_focal_y    = i_cfg.data[23:0];
                REG_CENTER_X:    n_cfg.center_x       = i_cfg.data[15:0];
                REG_CENTER_Y:    n_cfg.center_y       = i_cfg.data[15:0];
                REG_DEPTH_MIN:   n_cfg.near_mm        = i_cfg.data[15:0];
                REG_DEPTH_MAX:   n_cfg.far_mm         = i_cfg.data[15:0];
                REG_EXCL_LIST:   n_cfg.excluded_list  = i_cfg.data;
                REG_EXCL_COUNT:  n_cfg.excluded_count = i_cfg.data[2:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_focal_x    <= INV_FX_RST;
            r_cfg.inv_focal_y    <= INV_FY_RST;
            r_cfg.center_x       <= CENTER_X_RST;
            r_cfg.center_y       <= CENTER_Y_RST;
            r_cfg.near_mm        <= DEPTH_MIN_RST;
            r_cfg.far_mm         <= DEPTH_MAX_RST;
            r_cfg.excluded_list  <= EXCL_LIST_RST;
            r_cfg.excluded_count <= EXCL_CNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/dpfb_filter.sv]
module dpfb_filter
    import dpfb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  t_pix  i_pix,
    input  t_cfg  i_cfg,
    output logic  o_keep
);

    localparam logic [12:0] W_LIM = 13'(IMAGE_WIDTH - 2);
    localparam logic [12:0] H_LIM = 13'(IMAGE_HEIGHT - 2);

    function automatic logic is_edge(input logic [15:0] z, input logic [15:0] n);
        logic [15:0] d;
        d = (z > n) ? (z - n) : (n - z);
        return (n != 16'd0) && (d > EDGE_JUMP_MM);
    endfunction

    logic       depth_bad;
    logic       excluded;
    logic       orphan;
    logic       interior;
    logic       edge_hit;

    assign depth_bad = (i_pix.depth_mm == 16'd0) || (i_pix.depth_mm <= i_cfg.near_mm)
                    || (i_pix.depth_mm >= i_cfg.far_mm);

    // count above four covers every slot
    always_comb begin
        excluded = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((i_cfg.excluded_count > 3'(i))
                && (i_cfg.excluded_list[8*i +: 8] == i_pix.mask_label)) begin
                excluded = 1'b1;
            end
        end
    end

    assign orphan = (i_pix.mask_label != BACKGROUND_LABEL) && (i_pix.instance_in == 16'd0);

    assign interior = (i_pix.row > 12'd1) && ({1'b0, i_pix.row} < H_LIM)
                   && (i_pix.col > 12'd1) && ({1'b0, i_pix.col} < W_LIM);

    assign edge_hit = is_edge(i_pix.depth_mm, i_pix.depth_up)
                   || is_edge(i_pix.depth_mm, i_pix.depth_down)
                   || is_edge(i_pix.depth_mm, i_pix.depth_left)
                   || is_edge(i_pix.depth_mm, i_pix.depth_right);

    assign o_keep = !depth_bad && !excluded && !orphan && !(interior && edge_hit);

endmodule

[rtl/dpfb_project.sv]
module dpfb_project
    import dpfb_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic [11:0]        i_coord,
    input  logic [15:0]        i_center,
    input  logic [23:0]        i_inv,
    input  logic [15:0]        i_z,
    output logic signed [23:0] o_value
);

    // stage 1: offset from the principal point in 1/16 pixel
    logic signed [17:0] r_d;
    // stage 2: |d| * z
    logic [31:0]        r_pz;
    logic               r_neg2;
    // stage 3: * inv focal
    logic [PROD_W-1:0]  r_prod;
    logic               r_neg3;
    // stage 4: rounded and saturated
    logic signed [23:0] r_val;

    logic signed [17:0] n_d;
    logic [17:0]        d_abs;
    logic [PROD_W:0]    rnd_sum;
    logic [28:0]        rnd_int;
    logic [24:0]        neg_mag;
    logic [23:0]        n_val;

    assign n_d   = $signed({2'b00, i_coord, 4'b0000}) - $signed({2'b00, i_center});
    assign d_abs = r_d[17] ? 18'(-r_d) : 18'(r_d);

    always_comb begin
        rnd_sum = {1'b0, r_prod} + ((PROD_W+1)'(1) << (FRAC_SHIFT - 1));
        rnd_int = rnd_sum[FRAC_SHIFT +: 29];
        neg_mag = (rnd_int > OUT_NEG_MAG) ? OUT_NEG_MAG[24:0] : rnd_int[24:0];
        if (!r_neg3) begin
            n_val = (rnd_int > OUT_MAX) ? OUT_MAX[23:0] : rnd_int[23:0];
        end else begin
            n_val = 24'(25'h1000000 - neg_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load1) begin
            r_d <= n_d;
        end
        if (i_ctl.load2) begin
            r_pz   <= d_abs[15:0] * i_z;
            r_neg2 <= r_d[17];
        end
        if (i_ctl.load3) begin
            r_prod <= PROD_W'(r_pz * i_inv);
            r_neg3 <= r_neg2;
        end
        if (i_ctl.load4) begin
            r_val <= $signed(n_val);
        end
    end

    assign o_value = r_val;

endmodule

[rtl/depth_pixel_filter_backproject.sv]
// depth pixel filter and pinhole back-projection
//
// i_pix carries one depth pixel per item (position, centre depth, the four
// neighbour depths two pixels away, label, instance id and colour). a pixel
// that fails the depth range, excluded-label, instance or edge check is
// dropped inside the block and produces nothing. a kept pixel leaves on
// o_pnt as one camera-space point in mm with packed label and colour.
// i_cfg writes the eight camera and filter registers; it is always ready and
// is meant to be written only while the block holds no item.
//
// an accepted item passes the four-stage pipeline (offset, |d|*z, *1/f, round
// and saturate) in order, each stage holding one item, and o_pnt.valid is the
// valid bit of the last stage. throughput: one item per clock while the
// receiver keeps o_pnt.ready high.
// each stage loads when it is empty or its successor loads, so bubbles
// close up and a stalled receiver only holds the output register; the input
// keeps accepting until every stage is full. nothing is lost or repeated.
// reset clears the stage valid bits and sets the registers to their defaults.
module depth_pixel_filter_backproject
    import dpfb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dpfb_pix_if.sink     i_pix,
    dpfb_cfg_if.sink     i_cfg,
    dpfb_pnt_if.source   o_pnt
);

    t_cfg      cfg;
    t_pix      pix;
    t_pipe_ctl ctl;
    logic      keep;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;

    // side payload that rides alongside the arithmetic
    logic [15:0] r_z1, r_z2, r_z3, r_z4;
    logic [31:0] r_lab1, r_lab2, r_lab3, r_lab4;
    logic [23:0] r_rgb1, r_rgb2, r_rgb3, r_rgb4;
    logic [31:0] n_lab;

    dpfb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign pix.col         = i_pix.col;
    assign pix.row         = i_pix.row;
    assign pix.depth_mm    = i_pix.depth_mm;
    assign pix.depth_up    = i_pix.depth_up;
    assign pix.depth_down  = i_pix.depth_down;
    assign pix.depth_left  = i_pix.depth_left;
    assign pix.depth_right = i_pix.depth_right;
    assign pix.mask_label  = i_pix.mask_label;
    assign pix.instance_in = i_pix.instance_in;

    dpfb_filter #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_filter (
        .i_pix  (pix),
        .i_cfg  (cfg),
        .o_keep (keep)
    );

    // a stage loads when empty or when the stage after it loads
    assign ctl.load4 = !r_v4 || o_pnt.ready;
    assign ctl.load3 = !r_v3 || ctl.load4;
    assign ctl.load2 = !r_v2 || ctl.load3;
    assign ctl.load1 = !r_v1 || ctl.load2;

    assign i_pix.ready = ctl.load1;

    // dropped pixels never enter stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ctl.load1) r_v1 <= i_pix.valid && keep;
            if (ctl.load2) r_v2 <= r_v1;
            if (ctl.load3) r_v3 <= r_v2;
            if (ctl.load4) r_v4 <= r_v3;
        end
    end

    // background keeps 255, anything else packs the instance above the class
    assign n_lab = (i_pix.mask_label == BACKGROUND_LABEL) ? 32'(BACKGROUND_LABEL)
                 : ((32'(i_pix.instance_in) << INSTANCE_SHIFT) | 32'(i_pix.mask_label));

    always_ff @(posedge i_clk) begin
        if (ctl.load1) begin
            r_z1   <= i_pix.depth_mm;
            r_lab1 <= n_lab;
            r_rgb1 <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
        if (ctl.load2) begin
            r_z2   <= r_z1;
            r_lab2 <= r_lab1;
            r_rgb2 <= r_rgb1;
        end
        if (ctl.load3) begin
            r_z3   <= r_z2;
            r_lab3 <= r_lab2;
            r_rgb3 <= r_rgb2;
        end
        if (ctl.load4) begin
            r_z4   <= r_z3;
            r_lab4 <= r_lab3;
            r_rgb4 <= r_rgb3;
        end
    end

    // one projection lane per axis
    dpfb_project u_proj_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coord  (i_pix.col),
        .i_center (cfg.center_x),
        .i_inv    (cfg.inv_focal_x),
        .i_z      (r_z1),
        .o_value  (o_pnt.point_x)
    );

    dpfb_project u_proj_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coord  (i_pix.row),
        .i_center (cfg.center_y),
        .i_inv    (cfg.inv_focal_y),
        .i_z      (r_z1),
        .o_value  (o_pnt.point_y)
    );

    assign o_pnt.valid       = r_v4;
    assign o_pnt.point_z     = r_z4;
    assign o_pnt.point_label = r_lab4;
    assign o_pnt.red_out     = r_rgb4[23:16];
    assign o_pnt.green_out   = r_rgb4[15:8];
    assign o_pnt.blue_out    = r_rgb4[7:0];

    // a stalled result keeps its place, its depth and its label
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !o_pnt.ready |=> r_v4 && $stable(r_z4) && $stable(r_lab4))
        else $error("stalled output item changed");

    // an empty first stage never refuses an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_pix.ready)
        else $error("input refused with empty first stage");

    // a non-background point always carries a live instance
    a_label_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_lab4 == 32'(BACKGROUND_LABEL))
              || (r_lab4[15:8] == 8'd0 && r_lab4[31:16] != 16'd0
                  && r_lab4[7:0] != BACKGROUND_LABEL))
        else $error("malformed point label");

    // a point never leaves with zero depth
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_z4 != 16'd0)
        else $error("zero depth point emitted");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb
    import dpfb_pkg::*;
();

    // one pixel as offered on the input channel
    typedef struct packed {
        t_pix        px;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pixel;

    // one camera-space point as expected on the output channel
    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] z;
        logic [31:0] label;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_point;

    logic i_clk;
    logic i_rst_n;

    dpfb_pix_if pix ();
    dpfb_cfg_if cfg ();
    dpfb_pnt_if pnt ();

    depth_pixel_filter_backproject dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_pnt   (pnt)
    );

    // camera and filter registers as the block should hold them
    t_cfg   cam_cfg;
    // points still owed by the block, oldest first
    t_point point_q[$];

    int err_count      = 0;
    int pixels_sent    = 0;
    int pixels_dropped = 0;
    int points_seen    = 0;

    // idling switches for each side, and a hold-off counted down by the receiver
    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;
    int hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // a valid neighbour further than the jump limit marks a depth edge
    function automatic bit is_jump(input logic [15:0] z, input logic [15:0] n);
        if (n == 16'd0) return 1'b0;
        return ((z > n) ? (z - n) : (n - z)) > EDGE_JUMP_MM;
    endfunction

    // offset in 1/16 pixel times depth times Q0.24 inverse focal length,
    // rounded half away from zero and clipped to 24 bits signed
    function automatic logic [23:0] project_mm(input logic [11:0] pos,
                                               input logic [15:0] centre,
                                               input logic [15:0] z,
                                               input logic [23:0] inv);
        longint          offs;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned r;
        longint unsigned wrapped;
        offs = longint'(pos);
        offs = offs * 16 - centre;
        mag  = (offs < 0) ? -offs : offs;
        prod = mag * z * inv;
        r    = (prod + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        if (offs >= 0) begin
            if (r > OUT_MAX) r = OUT_MAX;
            return r[23:0];
        end
        if (r > OUT_NEG_MAG) r = OUT_NEG_MAG;
        wrapped = 64'h100_0000 - r;
        return wrapped[23:0];
    endfunction

    // returns 1 and the point when the pixel survives every filter
    function automatic bit predict_point(input t_pixel p, output t_point pt);
        logic [2:0] active;
        bit         interior;
        pt = '0;
        if (p.px.depth_mm == 16'd0 || p.px.depth_mm <= cam_cfg.near_mm ||
            p.px.depth_mm >= cam_cfg.far_mm) return 1'b0;

        // counts above four behave as four
        active = (cam_cfg.excluded_count > 3'd4) ? 3'd4 : cam_cfg.excluded_count;
        for (int i = 0; i < 4; i++) begin
            if (i < active && cam_cfg.excluded_list[8*i +: 8] == p.px.mask_label)
                return 1'b0;
        end

        if (p.px.mask_label != BACKGROUND_LABEL && p.px.instance_in == 16'd0)
            return 1'b0;

        interior = p.px.row > 1 && p.px.row < IMAGE_HEIGHT_DEF - 2 &&
                   p.px.col > 1 && p.px.col < IMAGE_WIDTH_DEF - 2;
        if (interior && (is_jump(p.px.depth_mm, p.px.depth_up) ||
                         is_jump(p.px.depth_mm, p.px.depth_down) ||
                         is_jump(p.px.depth_mm, p.px.depth_left) ||
                         is_jump(p.px.depth_mm, p.px.depth_right)))
            return 1'b0;

        pt.x     = project_mm(p.px.col, cam_cfg.center_x, p.px.depth_mm,
                              cam_cfg.inv_focal_x);
        pt.y     = project_mm(p.px.row, cam_cfg.center_y, p.px.depth_mm,
                              cam_cfg.inv_focal_y);
        pt.z     = p.px.depth_mm;
        pt.label = (p.px.mask_label == BACKGROUND_LABEL) ? {24'd0, BACKGROUND_LABEL}
                 : {p.px.instance_in, 8'd0, p.px.mask_label};
        pt.blue  = p.blue;
        pt.green = p.green;
        pt.red   = p.red;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // pixel whose neighbours all match its own depth
    function automatic t_pixel flat_pixel(input int col, row, z, label, inst);
        t_pixel p;
        p.px.col         = 12'(col);
        p.px.row         = 12'(row);
        p.px.depth_mm    = 16'(z);
        p.px.depth_up    = 16'(z);
        p.px.depth_down  = 16'(z);
        p.px.depth_left  = 16'(z);
        p.px.depth_right = 16'(z);
        p.px.mask_label  = 8'(label);
        p.px.instance_in = 16'(inst);
        p.blue           = 8'($urandom_range(0, 255));
        p.green          = 8'($urandom_range(0, 255));
        p.red            = 8'($urandom_range(0, 255));
        return p;
    endfunction

    // mostly within the edge limit of the centre, sometimes zero or anywhere
    function automatic logic [15:0] neighbour_depth(input logic [15:0] z);
        int pick;
        int t;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            t = z;
            t = t + int'($urandom_range(0, 400)) - 200;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            return t[15:0];
        end
        if (pick < 80) return 16'd0;
        return 16'($urandom_range(0, 65535));
    endfunction

    // weighted towards pixels that pass, with borders, bad depths and labels mixed in
    function automatic t_pixel rand_pixel();
        t_pixel p;
        int     pick;
        int     lo;
        int     hi;
        pick = $urandom_range(0, 9);
        if (pick == 0)      p.px.col = 12'($urandom_range(0, 4095));
        else if (pick == 1) p.px.col = 12'($urandom_range(0, 3));
        else if (pick == 2) p.px.col = 12'(IMAGE_WIDTH_DEF - 4 + $urandom_range(0, 3));
        else                p.px.col = 12'($urandom_range(0, IMAGE_WIDTH_DEF - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)      p.px.row = 12'($urandom_range(0, 4095));
        else if (pick == 1) p.px.row = 12'($urandom_range(0, 3));
        else if (pick == 2) p.px.row = 12'(IMAGE_HEIGHT_DEF - 4 + $urandom_range(0, 3));
        else                p.px.row = 12'($urandom_range(0, IMAGE_HEIGHT_DEF - 1));

        lo   = int'(cam_cfg.near_mm);
        hi   = int'(cam_cfg.far_mm);
        pick = $urandom_range(0, 19);
        if (pick == 0)           p.px.depth_mm = 16'd0;
        else if (pick == 1)      p.px.depth_mm = 16'($urandom_range(0, 65535));
        else if (pick == 2)      p.px.depth_mm = 16'(lo + $urandom_range(0, 1));
        else if (pick == 3)      p.px.depth_mm = 16'(hi - $urandom_range(0, 1));
        else if (hi > lo + 1)    p.px.depth_mm = 16'($urandom_range(lo + 1, hi - 1));
        else                     p.px.depth_mm = 16'($urandom_range(0, 65535));

        p.px.depth_up    = neighbour_depth(p.px.depth_mm);
        p.px.depth_down  = neighbour_depth(p.px.depth_mm);
        p.px.depth_left  = neighbour_depth(p.px.depth_mm);
        p.px.depth_right = neighbour_depth(p.px.depth_mm);

        pick = $urandom_range(0, 99);
        if (pick < 20)      p.px.mask_label = BACKGROUND_LABEL;
        else if (pick < 35) p.px.mask_label =
                                cam_cfg.excluded_list[8*$urandom_range(0, 3) +: 8];
        else                p.px.mask_label = 8'($urandom_range(0, 255));
        p.px.instance_in = ($urandom_range(0, 9) == 0) ? 16'd0
                         : 16'($urandom_range(1, 65535));

        p.blue  = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.red   = 8'($urandom_range(0, 255));
        return p;
    endfunction

    // offer one pixel, hold it until accepted, then book the expected point
    task automatic send_pixel(input t_pixel p);
        t_point pt;
        @(negedge i_clk);
        while (src_idle && $urandom_range(0, 99) < 32) begin
            pix.valid = 1'b0;
            @(negedge i_clk);
        end
        pix.col         = p.px.col;
        pix.row         = p.px.row;
        pix.depth_mm    = p.px.depth_mm;
        pix.depth_up    = p.px.depth_up;
        pix.depth_down  = p.px.depth_down;
        pix.depth_left  = p.px.depth_left;
        pix.depth_right = p.px.depth_right;
        pix.mask_label  = p.px.mask_label;
        pix.instance_in = p.px.instance_in;
        pix.blue_in     = p.blue;
        pix.green_in    = p.green;
        pix.red_in      = p.red;
        pix.valid       = 1'b1;
        do @(posedge i_clk); while (!pix.ready);
        pixels_sent++;
        if (predict_point(p, pt)) point_q = {point_q, pt};
        else pixels_dropped++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // stop offering, let every owed point out, then idle on to cover items still
    // in flight that will never produce a point
    task automatic wait_idle();
        @(negedge i_clk);
        pix.valid = 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_INV_FOCAL_X: cam_cfg.inv_focal_x    = value[23:0];
            REG_INV_FOCAL_Y: cam_cfg.inv_focal_y    = value[23:0];
            REG_CENTER_X:    cam_cfg.center_x       = value[15:0];
            REG_CENTER_Y:    cam_cfg.center_y       = value[15:0];
            REG_DEPTH_MIN:   cam_cfg.near_mm        = value[15:0];
            REG_DEPTH_MAX:   cam_cfg.far_mm         = value[15:0];
            REG_EXCL_LIST:   cam_cfg.excluded_list  = value;
            REG_EXCL_COUNT:  cam_cfg.excluded_count = value[2:0];
        endcase
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_camera(input logic [23:0] fx, fy, input logic [15:0] cx, cy,
                              input logic [15:0] dmin, dmax, input logic [31:0] list,
                              input logic [2:0] count);
        write_reg(REG_INV_FOCAL_X, {8'd0, fx});
        write_reg(REG_INV_FOCAL_Y, {8'd0, fy});
        write_reg(REG_CENTER_X,    {16'd0, cx});
        write_reg(REG_CENTER_Y,    {16'd0, cy});
        write_reg(REG_DEPTH_MIN,   {16'd0, dmin});
        write_reg(REG_DEPTH_MAX,   {16'd0, dmax});
        write_reg(REG_EXCL_LIST,   list);
        write_reg(REG_EXCL_COUNT,  {29'd0, count});
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: range 100..8000 exclusive, label 0 excluded
    task automatic test_directed();
        t_pixel p;
        send_pixel(flat_pixel(320, 240, 0, 255, 0));        // zero depth
        send_pixel(flat_pixel(320, 240, 100, 3, 1));        // on lower bound
        send_pixel(flat_pixel(320, 240, 101, 3, 1));
        send_pixel(flat_pixel(320, 240, 7999, 3, 1));
        send_pixel(flat_pixel(320, 240, 8000, 3, 1));       // on upper bound
        send_pixel(flat_pixel(320, 240, 65535, 3, 1));
        send_pixel(flat_pixel(100, 200, 1500, 0, 7));       // excluded label
        send_pixel(flat_pixel(100, 200, 1500, 255, 0));     // background, no instance
        send_pixel(flat_pixel(100, 200, 1500, 9, 0));       // object, no instance
        send_pixel(flat_pixel(100, 200, 1500, 254, 65535));

        // neighbour edge limit from each side
        p = flat_pixel(200, 300, 2000, 4, 2);
        p.px.depth_up = 2201;
        send_pixel(p);
        p.px.depth_up = 2200;
        p.px.depth_down = 1800;
        send_pixel(p);
        p.px.depth_down = 1799;
        send_pixel(p);
        p = flat_pixel(200, 300, 2000, 4, 2);
        p.px.depth_left = 2201;
        send_pixel(p);
        p = flat_pixel(200, 300, 2000, 4, 2);
        p.px.depth_right = 1799;
        send_pixel(p);
        p = flat_pixel(200, 300, 2000, 4, 2);
        p.px.depth_up = 0;
        p.px.depth_down = 0;
        p.px.depth_left = 0;
        p.px.depth_right = 0;
        send_pixel(p);

        // border pixels ignore wild neighbours, the first interior ones do not
        p = flat_pixel(1, 240, 3000, 255, 0);
        p.px.depth_up = 65535;
        send_pixel(p);
        p.px.col = IMAGE_WIDTH_DEF - 2;
        send_pixel(p);
        p.px.col = 320;
        p.px.row = 1;
        send_pixel(p);
        p.px.row = IMAGE_HEIGHT_DEF - 2;
        send_pixel(p);
        p.px.col = 2;
        p.px.row = 2;
        send_pixel(p);
        p.px.col = IMAGE_WIDTH_DEF - 3;
        p.px.row = IMAGE_HEIGHT_DEF - 3;
        send_pixel(p);

        // far corners of the coordinate range, colour extremes
        p = flat_pixel(0, 0, 7000, 255, 0);
        p.blue = 8'h00;
        p.green = 8'h00;
        p.red = 8'h00;
        send_pixel(p);
        p = flat_pixel(4095, 4095, 7000, 128, 16'h8001);
        p.blue = 8'hFF;
        p.green = 8'hFF;
        p.red = 8'hFF;
        send_pixel(p);
        send_random(300);
    endtask

    // widest range, largest and smallest focal inverse, full exclusion list
    task automatic test_extremes();
        wait_idle();
        set_camera(24'hFF_FFFF, 24'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                   32'hFF0A_0B0C, 3'd4);
        send_pixel(flat_pixel(320, 240, 0, 200, 1));        // zero depth, min is 0
        send_pixel(flat_pixel(4095, 0, 65534, 200, 1));     // x clips high
        send_pixel(flat_pixel(100, 100, 1, 200, 1));
        send_pixel(flat_pixel(50, 60, 500, 12, 9));         // list entry 0
        send_pixel(flat_pixel(50, 60, 500, 10, 9));         // list entry 2
        send_pixel(flat_pixel(50, 60, 500, 255, 0));        // background excluded too
        send_random(150);
    endtask

    // empty and inverted depth ranges, zero focal inverse, count beyond four and zero
    task automatic test_ranges_and_focal();
        wait_idle();
        set_camera(24'hFF_FFFF, 24'd0, 16'hFFFF, 16'd0, 16'd1000, 16'd1001,
                   $urandom, 3'd7);
        send_random(40);
        wait_idle();
        write_reg(REG_DEPTH_MIN, 32'd2000);
        write_reg(REG_DEPTH_MAX, 32'd1000);
        send_random(30);
        wait_idle();
        write_reg(REG_DEPTH_MIN, 32'd1000);
        write_reg(REG_DEPTH_MAX, 32'd3000);
        write_reg(REG_EXCL_COUNT, 32'd0);
        send_pixel(flat_pixel(0, 4095, 2999, 0, 5));        // x clips low, y is zero
        send_random(150);
    endtask

    task automatic test_random_config();
        repeat (3) begin
            wait_idle();
            set_camera(24'($urandom_range(16000, 70000)), 24'($urandom_range(16000, 70000)),
                       16'($urandom_range(0, 16 * 700)), 16'($urandom_range(0, 16 * 520)),
                       16'($urandom_range(0, 600)), 16'($urandom_range(2000, 65535)),
                       $urandom, 3'($urandom_range(0, 7)));
            send_random(150);
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        wait_idle();
        set_camera(INV_FX_RST, INV_FY_RST, CENTER_X_RST, CENTER_Y_RST,
                   DEPTH_MIN_RST, DEPTH_MAX_RST, EXCL_LIST_RST, EXCL_CNT_RST);
        src_idle    = 1'b0;
        hold_cycles = 300;
        send_random(120);
        src_idle    = 1'b1;
    endtask

    // back-to-back items with the receiver always ready
    task automatic test_full_rate();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_random(200);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    initial begin : drive_ready
        pnt.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                pnt.ready = 1'b0;
                hold_cycles--;
            end else begin
                pnt.ready = !sink_idle || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    initial begin : check_points
        t_point want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pnt.valid && pnt.ready) begin
                if (point_q.size() == 0) begin
                    $error("point with no pixel owed: x 0x%0h y 0x%0h z %0d",
                           pnt.point_x, pnt.point_y, pnt.point_z);
                    err_count++;
                end else begin
                    want = point_q.pop_front();
                    check_field("point_x", {8'd0, want.x}, {8'd0, pnt.point_x});
                    check_field("point_y", {8'd0, want.y}, {8'd0, pnt.point_y});
                    check_field("point_z", {16'd0, want.z}, {16'd0, pnt.point_z});
                    check_field("point_label", want.label, pnt.point_label);
                    check_field("blue_out", {24'd0, want.blue}, {24'd0, pnt.blue_out});
                    check_field("green_out", {24'd0, want.green}, {24'd0, pnt.green_out});
                    check_field("red_out", {24'd0, want.red}, {24'd0, pnt.red_out});
                    points_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         = 1'b0;
        pix.valid       = 1'b0;
        pix.col         = '0;
        pix.row         = '0;
        pix.depth_mm    = '0;
        pix.depth_up    = '0;
        pix.depth_down  = '0;
        pix.depth_left  = '0;
        pix.depth_right = '0;
        pix.mask_label  = '0;
        pix.instance_in = '0;
        pix.blue_in     = '0;
        pix.green_in    = '0;
        pix.red_in      = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_INV_FOCAL_X;
        cfg.data        = '0;

        cam_cfg.inv_focal_x    = INV_FX_RST;
        cam_cfg.inv_focal_y    = INV_FY_RST;
        cam_cfg.center_x       = CENTER_X_RST;
        cam_cfg.center_y       = CENTER_Y_RST;
        cam_cfg.near_mm        = DEPTH_MIN_RST;
        cam_cfg.far_mm         = DEPTH_MAX_RST;
        cam_cfg.excluded_list  = EXCL_LIST_RST;
        cam_cfg.excluded_count = EXCL_CNT_RST;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_extremes();
        test_ranges_and_focal();
        test_random_config();
        test_backpressure();
        test_full_rate();
        wait_idle();

        $display("%0d pixel items accepted, %0d points checked, %0d pixels filtered out",
                 pixels_sent, points_seen, pixels_dropped);
        $display("depth bounds, exclusion list, instance, edge, border and clipping cases %s",
                 "under random idling, a long receiver hold-off and full rate");
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/dpfb_pkg.sv
rtl/dpfb_ifs.sv
rtl/dpfb_cfg_regs.sv
rtl/dpfb_filter.sv
rtl/dpfb_project.sv
rtl/depth_pixel_filter_backproject.sv
sim/tb.sv
